[rtl/ihpc_pkg.sv]
// Shared types, constants and helpers for the IPv4 header parse/check core.
// No dependencies; imported by every module in rtl/.
package ihpc_pkg;

    localparam int HDR_BYTES   = 20;
    localparam int POS_W       = $clog2(HDR_BYTES + 1);
    localparam int CAP_DEPTH   = HDR_BYTES - 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HDR_BYTES - 1);
    localparam logic [POS_W-1:0] DONE_POS = POS_W'(HDR_BYTES);

    localparam logic [15:0] VER4_BIAS   = 16'h0040;
    localparam logic [15:0] MIN_HDR_LEN = 16'd20;
    localparam logic [15:0] SUM_ALL_ONE = 16'hFFFF;

    // Input transaction
    typedef struct packed {
        logic [7:0] header_byte;
        logic       first_byte;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [7:0]  version_ihl;
        logic [7:0]  service_type;
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [15:0] flags_offset;
        logic [7:0]  hop_limit;
        logic [7:0]  proto_byte;
        logic [15:0] header_sum_field;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic        checksum_ok;
        logic        options_or_fragment;
    } t_out;

    // Complete raw header plus its final ones'-complement sum
    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] bytes;
        logic [15:0]               sum;
    } t_raw_hdr;

    // Ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

[rtl/ipv4_header_parse_check_core.sv]
// IPv4 fixed-header parser with header checksum check: top level.
// The result is registered and appears in the cycle after the transaction carrying byte 19.
// Throughput: one header byte per cycle; the only stall is byte 19 arriving
// while the previous result still sits unread in the result register.
// Reset (i_rst_n low, synchronous) clears position, sum and result valid.
// Depends on ihpc_pkg, ihpc_collect, ihpc_check.
module ipv4_header_parse_check_core
    import ihpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // header byte stream
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    // parsed header results
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic     take;
    logic     last_pending;
    logic     emit;
    logic     stalled;
    t_raw_hdr raw;

    // Only the closing byte of a header loads the result register, so every
    // other byte is taken even while a result waits downstream. A byte with
    // first_byte set always restarts at position 0 and never closes a header.
    assign o_in_ready = !stalled || !last_pending || i_in_data.first_byte;
    assign take       = i_in_valid && o_in_ready;

    // Position counter, running ones'-complement sum, byte capture
    ihpc_collect u_collect (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_in           (i_in_data),
        .o_last_pending (last_pending),
        .o_emit         (emit),
        .o_raw          (raw)
    );

    // Field slicing, checksum and length checks, result register
    ihpc_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit),
        .i_raw       (raw),
        .i_out_ready (i_out_ready),
        .o_stalled   (stalled),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule

[rtl/ihpc_collect.sv]
// Byte collector: position counter, running checksum and byte capture.
// Depends on ihpc_pkg.
module ihpc_collect
    import ihpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in      i_in,
    output logic     o_last_pending,
    output logic     o_emit,
    output t_raw_hdr o_raw
);

    logic [POS_W-1:0] r_pos, n_pos, pos_eff;
    logic [15:0]      r_sum, n_sum, sum_eff;
    logic [7:0]       r_hold, n_hold, hold_eff;
    logic [7:0]       r_cap [CAP_DEPTH];

    always_comb begin
        pos_eff  = i_in.first_byte ? '0 : r_pos;
        sum_eff  = i_in.first_byte ? '0 : r_sum;
        hold_eff = i_in.first_byte ? '0 : r_hold;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_hold   = r_hold;
        if (i_take) begin
            n_pos  = pos_eff;
            n_sum  = sum_eff;
            n_hold = hold_eff;
            if (pos_eff < DONE_POS) begin
                if (pos_eff[0]) begin
                    n_sum = oc_add(sum_eff, {hold_eff, i_in.header_byte});
                end else begin
                    n_hold = i_in.header_byte;
                end
                n_pos = pos_eff + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_hold <= '0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_hold <= n_hold;
        end
    end

    // Capture store, no reset: every entry is written before a result reads it
    always_ff @(posedge i_clk) begin
        if (i_take && pos_eff < LAST_POS) begin
            r_cap[pos_eff] <= i_in.header_byte;
        end
    end

    assign o_last_pending = (r_pos == LAST_POS);
    assign o_emit         = i_take && (pos_eff == LAST_POS);

    always_comb begin
        for (int i = 0; i < CAP_DEPTH; i++) begin
            o_raw.bytes[i] = r_cap[i];
        end
        o_raw.bytes[HDR_BYTES-1] = i_in.header_byte;
        o_raw.sum = n_sum;
    end

endmodule

[rtl/ihpc_check.sv]
// Field extraction, checksum/length checks and the result register.
// Depends on ihpc_pkg.
module ihpc_check
    import ihpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_raw_hdr i_raw,
    input  logic     i_out_ready,
    output logic     o_stalled,
    output logic     o_out_valid,
    output t_out     o_out
);

    logic        r_valid;
    t_out        r_out, n_out;
    logic [15:0] len_base, hdr_len;

    always_comb begin
        len_base = {8'h00, i_raw.bytes[0]} - VER4_BIAS;
        hdr_len  = {len_base[13:0], 2'b00};

        n_out.version_ihl      = i_raw.bytes[0];
        n_out.service_type     = i_raw.bytes[1];
        n_out.total_length     = {i_raw.bytes[2], i_raw.bytes[3]};
        n_out.ident            = {i_raw.bytes[4], i_raw.bytes[5]};
        n_out.flags_offset     = {i_raw.bytes[6], i_raw.bytes[7]};
        n_out.hop_limit        = i_raw.bytes[8];
        n_out.proto_byte       = i_raw.bytes[9];
        n_out.header_sum_field = {i_raw.bytes[10], i_raw.bytes[11]};
        n_out.source_addr      = {i_raw.bytes[12], i_raw.bytes[13],
                                  i_raw.bytes[14], i_raw.bytes[15]};
        n_out.dest_addr        = {i_raw.bytes[16], i_raw.bytes[17],
                                  i_raw.bytes[18], i_raw.bytes[19]};
        n_out.checksum_ok      = (i_raw.sum == SUM_ALL_ONE)
                                 && (n_out.header_sum_field != 16'd0)
                                 && (hdr_len >= MIN_HDR_LEN);
        n_out.options_or_fragment = (hdr_len > MIN_HDR_LEN)
                                    || (n_out.ident != 16'd0)
                                    || (n_out.flags_offset != 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

    assign o_stalled   = r_valid && !i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for ipv4_header_parse_check_core: directed headers, then random streams.
// Depends on rtl/ihpc_pkg.sv and rtl/ipv4_header_parse_check_core.sv.
`timescale 1ns / 100ps

module tb_top;
    import ihpc_pkg::*;

    // Header bytes in network order: index 0 is the first byte on the wire.
    typedef logic [0:HDR_BYTES-1][7:0] t_hdr_bytes;

    // One directed row: a header sent byte by byte, optionally truncated or
    // followed by stray bytes, with a hand-written result where obvious.
    typedef struct {
        bit         mark;     // set first_byte on byte 0
        int         nbytes;   // <20 truncates, >20 appends stray bytes
        t_hdr_bytes hdr;
        bit         typed;    // want holds the result written out by hand
        t_out       want;
    } t_dir_row;

    localparam int ITEM_TARGET = 1150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 6;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    ipv4_header_parse_check_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Parsed headers still owed by the block, oldest first.
    t_out hdr_q [$];

    int err_cnt     = 0;
    int items_taken = 0;   // bytes the parser actually consumed
    int snd_idle    = 13;  // percent of cycles the sender holds valid low
    int rcv_idle    = 66;  // percent of cycles the receiver holds ready low
    int cyc_cnt     = 0;

    // Hand-written expectation for the header in flight, if any.
    bit   typed_pending = 1'b0;
    t_out typed_want;

    // ------------------------------------------------------------------
    // Parser shadow state
    // ------------------------------------------------------------------
    logic [4:0]  pm_pos  = '0;   // next expected byte index, 0..20
    logic [15:0] pm_sum  = '0;   // ones'-complement sum of complete words
    logic [7:0]  pm_hold = '0;   // even byte of the current word
    logic [7:0]  pm_cap [CAP_DEPTH];

    // 16-bit ones'-complement add, end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Advance the shadow parser by one byte. taken is low when the byte is
    // dropped (header already complete); emit is high after byte 19.
    task automatic parse_byte(input t_in it, output bit taken, output bit emit,
                              output t_out res);
        logic [7:0]  b;
        logic [15:0] hlen;
        b     = it.header_byte;
        emit  = 1'b0;
        res   = '0;
        if (it.first_byte) begin
            pm_pos  = '0;
            pm_sum  = '0;
            pm_hold = '0;
        end
        taken = (pm_pos < HDR_BYTES);
        if (!taken)
            return;
        // odd position closes a big-endian word
        if (pm_pos[0])
            pm_sum = ones_add(pm_sum, {pm_hold, b});
        else
            pm_hold = b;
        if (pm_pos < HDR_BYTES - 1) begin
            pm_cap[pm_pos] = b;
            pm_pos = pm_pos + 5'd1;
        end else begin
            pm_pos = 5'(HDR_BYTES);
            // header length wraps mod 65536 for versions below 4
            hlen = ({8'd0, pm_cap[0]} - VER4_BIAS) << 2;
            res.version_ihl      = pm_cap[0];
            res.service_type     = pm_cap[1];
            res.total_length     = {pm_cap[2], pm_cap[3]};
            res.ident            = {pm_cap[4], pm_cap[5]};
            res.flags_offset     = {pm_cap[6], pm_cap[7]};
            res.hop_limit        = pm_cap[8];
            res.proto_byte       = pm_cap[9];
            res.header_sum_field = {pm_cap[10], pm_cap[11]};
            res.source_addr      = {pm_cap[12], pm_cap[13], pm_cap[14], pm_cap[15]};
            res.dest_addr        = {pm_cap[16], pm_cap[17], pm_cap[18], b};
            res.checksum_ok      = (~pm_sum == 16'h0000) && (res.header_sum_field != 16'h0000)
                                   && (hlen >= MIN_HDR_LEN);
            res.options_or_fragment = (hlen > MIN_HDR_LEN) || (res.ident != 16'h0000)
                                      || (res.flags_offset != 16'h0000);
            emit = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: one byte transaction, with random idle cycles ahead of it.
    // Returns at the edge where the transaction is accepted.
    // ------------------------------------------------------------------
    task automatic send_item(input t_in it);
        bit   taken;
        bit   emit;
        t_out res;
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        parse_byte(it, taken, emit, res);
        if (taken)
            items_taken++;
        if (emit) begin
            if (typed_pending) begin
                hdr_q.push_back(typed_want);
                typed_pending = 1'b0;
            end else begin
                hdr_q.push_back(res);
            end
        end
    endtask

    // Send the first nsend bytes of a header; bytes past 20 are random strays.
    task automatic send_hdr(input t_hdr_bytes h, input bit mark, input int nsend);
        t_in it;
        for (int i = 0; i < nsend; i++) begin
            it.header_byte = (i < HDR_BYTES) ? h[i] : 8'($urandom);
            it.first_byte  = mark && (i == 0);
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed headers
    // ------------------------------------------------------------------
    t_dir_row dir_tab [DIR_ROWS] = '{
        // textbook header right after reset, no start mark, two stray bytes
        // after it that must be dropped; DF flag set so options flag is high
        '{1'b0, 22, 160'h4500_0073_0000_4000_4011_B861_C0A8_0001_C0A8_00C7, 1'b1,
          t_out'({8'h45, 8'h00, 16'h0073, 16'h0000, 16'h4000, 8'h40, 8'h11,
                  16'hB861, 32'hC0A8_0001, 32'hC0A8_00C7, 1'b1, 1'b1})},
        // partial header, abandoned by the next start mark
        '{1'b1, 5, 160'h4F11_2233_4455_6677_8899_AABB_CCDD_EEFF_0102_0304, 1'b0, '0},
        // all ones: sum is 0xFFFF, field nonzero, long header length
        '{1'b1, 20, {HDR_BYTES{8'hFF}}, 1'b1,
          t_out'({8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1})},
        // all zeros: sum fails, header length wraps to 65280
        '{1'b1, 20, {HDR_BYTES{8'h00}}, 1'b1,
          t_out'({8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00,
                  16'h0000, 32'h0, 32'h0, 1'b0, 1'b1})},
        // sum verifies but checksum field is zero; plain 20-byte header
        '{1'b1, 20, 160'h45BA_BA45_0000_0000_0000_0000_0000_0000_0000_0000, 1'b1,
          t_out'({8'h45, 8'hBA, 16'hBA45, 16'h0000, 16'h0000, 8'h00, 8'h00,
                  16'h0000, 32'h0, 32'h0, 1'b0, 1'b0})},
        // sum verifies, field nonzero, but header length 16 is too short
        '{1'b1, 20, 160'h4400_0000_0000_0000_0000_BBFF_0000_0000_0000_0000, 1'b1,
          t_out'({8'h44, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00,
                  16'hBBFF, 32'h0, 32'h0, 1'b0, 1'b0})}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_hdr_bytes h;
        logic [15:0] s;
        int kind;
        int nsend;
        bit mark;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            typed_pending = dir_tab[r].typed;
            typed_want    = dir_tab[r].want;
            send_hdr(dir_tab[r].hdr, dir_tab[r].mark, dir_tab[r].nbytes);
        end

        // hold off until the block has handed over every parsed header
        i_in_valid <= 1'b0;
        while (hdr_q.size() != 0)
            @(posedge i_clk);

        // Random part: mostly well-formed headers, the rest broken or noise.
        while (items_taken < ITEM_TARGET) begin
            if (items_taken < ITEM_TARGET / 3) begin
                snd_idle = 13;
                rcv_idle = 66;
            end else if (items_taken < 2 * ITEM_TARGET / 3) begin
                snd_idle = 66;
                rcv_idle = 13;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end

            for (int i = 0; i < HDR_BYTES; i++)
                h[i] = 8'($urandom);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: h[0] = 8'h45;
                6, 7:             h[0] = {4'h4, 4'($urandom)};
                default:          ;
            endcase
            if ($urandom_range(1) == 0) {h[4], h[5]} = 16'h0000;
            case ($urandom_range(2))
                0:       {h[6], h[7]} = 16'h0000;
                1:       {h[6], h[7]} = 16'h4000;
                default: ;
            endcase
            // fill in a correct checksum most of the time
            if ($urandom_range(9) < 7) begin
                s = 16'h0000;
                for (int w = 0; w < HDR_BYTES / 2; w++)
                    if (w != 5)
                        s = ones_add(s, {h[2*w], h[2*w+1]});
                {h[10], h[11]} = ~s;
            end

            kind  = $urandom_range(99);
            mark  = 1'b1;
            nsend = HDR_BYTES;
            if (kind < 75) begin
                if ($urandom_range(9) == 0)
                    nsend = HDR_BYTES + $urandom_range(1, 3);
            end else if (kind < 83) begin
                nsend = $urandom_range(1, HDR_BYTES - 1);
            end else if (kind < 90) begin
                mark = 1'b0;
            end else begin
                // noise: random bytes with random start marks
                nsend = $urandom_range(1, 8);
                for (int i = 0; i < nsend; i++)
                    send_item(t_in'({8'($urandom), 1'($urandom)}));
                nsend = 0;
            end
            if (nsend != 0)
                send_hdr(h, mark, nsend);
        end

        i_in_valid <= 1'b0;
        while (hdr_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random backpressure, and field-by-field check of each
    // accepted result transaction against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_hdr(input t_out got, input t_out want);
        if (got.version_ihl !== want.version_ihl) begin
            $error("version_ihl: expected %h, got %h", want.version_ihl, got.version_ihl);
            err_cnt++;
        end
        if (got.service_type !== want.service_type) begin
            $error("service_type: expected %h, got %h", want.service_type, got.service_type);
            err_cnt++;
        end
        if (got.total_length !== want.total_length) begin
            $error("total_length: expected %h, got %h", want.total_length, got.total_length);
            err_cnt++;
        end
        if (got.ident !== want.ident) begin
            $error("ident: expected %h, got %h", want.ident, got.ident);
            err_cnt++;
        end
        if (got.flags_offset !== want.flags_offset) begin
            $error("flags_offset: expected %h, got %h", want.flags_offset, got.flags_offset);
            err_cnt++;
        end
        if (got.hop_limit !== want.hop_limit) begin
            $error("hop_limit: expected %h, got %h", want.hop_limit, got.hop_limit);
            err_cnt++;
        end
        if (got.proto_byte !== want.proto_byte) begin
            $error("proto_byte: expected %h, got %h", want.proto_byte, got.proto_byte);
            err_cnt++;
        end
        if (got.header_sum_field !== want.header_sum_field) begin
            $error("header_sum_field: expected %h, got %h",
                   want.header_sum_field, got.header_sum_field);
            err_cnt++;
        end
        if (got.source_addr !== want.source_addr) begin
            $error("source_addr: expected %h, got %h", want.source_addr, got.source_addr);
            err_cnt++;
        end
        if (got.dest_addr !== want.dest_addr) begin
            $error("dest_addr: expected %h, got %h", want.dest_addr, got.dest_addr);
            err_cnt++;
        end
        if (got.checksum_ok !== want.checksum_ok) begin
            $error("checksum_ok: expected %b, got %b", want.checksum_ok, got.checksum_ok);
            err_cnt++;
        end
        if (got.options_or_fragment !== want.options_or_fragment) begin
            $error("options_or_fragment: expected %b, got %b",
                   want.options_or_fragment, got.options_or_fragment);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (hdr_q.size() == 0) begin
                $error("result transaction with no header pending: %h", o_out_data);
                err_cnt++;
            end else begin
                check_hdr(o_out_data, hdr_q.pop_front());
            end
        end
        i_out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule
